// ----- rtl/sfdl_pkg.sv -----
// ----------------------------------------------------------------------------
// sfdl_pkg
// Shared widths, types, register codes and arithmetic helpers of the stereo
// feedback delay line.
// ----------------------------------------------------------------------------
package sfdl_pkg;

   localparam int DEPTH      = 65536;
   localparam int ADDR_W     = $clog2(DEPTH);
   localparam int SAMPLE_W   = 16;
   localparam int DELAY_W    = 16;
   localparam int SPREAD_W   = 12;
   localparam int FB_W       = 15;
   localparam int WET_W      = 16;
   localparam int FRAC_BITS  = 15;
   localparam int UNITY      = 32768;
   localparam int ROUND_HALF = 16384;
   localparam int CSR_IDX_W  = 4;
   localparam int CSR_DATA_W = 16;
   localparam int PROD_W     = 32;
   localparam int ACC_W      = 34;
   localparam int QUOT_W     = ACC_W - FRAC_BITS;
   localparam int DIST_W     = ((ADDR_W > DELAY_W) ? ADDR_W : DELAY_W) + 2;

   typedef logic signed [SAMPLE_W-1:0]   sample_type;
   typedef logic        [ADDR_W-1:0]     addr_type;
   typedef logic        [CSR_IDX_W-1:0]  csr_idx_type;
   typedef logic        [CSR_DATA_W-1:0] csr_data_type;
   typedef logic signed [PROD_W-1:0]     prod_type;
   typedef logic signed [ACC_W-1:0]      acc_type;
   typedef logic signed [DIST_W-1:0]     dist_type;

   // register indexes of the configuration port
   localparam csr_idx_type CSR_DELAY    = csr_idx_type'(0);
   localparam csr_idx_type CSR_SPREAD   = csr_idx_type'(1);
   localparam csr_idx_type CSR_FEEDBACK = csr_idx_type'(2);
   localparam csr_idx_type CSR_WET      = csr_idx_type'(3);

   localparam logic [DELAY_W-1:0]  DELAY_RESET    = DELAY_W'(24000);
   localparam logic [SPREAD_W-1:0] SPREAD_RESET   = SPREAD_W'(0);
   localparam logic [FB_W-1:0]     FEEDBACK_RESET = FB_W'(16384);
   localparam logic [WET_W-1:0]    WET_RESET      = WET_W'(16384);
   localparam logic [WET_W-1:0]    WET_UNITY      = WET_W'(UNITY);

   localparam sample_type SAMPLE_MAX = sample_type'(32767);
   localparam sample_type SAMPLE_MIN = sample_type'(-32768);
   localparam dist_type   DIST_MIN   = dist_type'(1);
   localparam dist_type   DIST_MAX   = dist_type'(DEPTH - 1);
   localparam addr_type   ADDR_LAST  = addr_type'(DEPTH - 1);

   // add half an lsb, floor shift by the fraction bits, clamp to 16 bits
   function automatic sample_type round_sat(acc_type acc);
      acc_type                  biased;
      logic signed [QUOT_W-1:0] quot;
      biased = acc + acc_type'(ROUND_HALF);
      quot   = $signed(biased[ACC_W-1:FRAC_BITS]);
      if (quot > QUOT_W'(SAMPLE_MAX) && !quot[QUOT_W-1]) begin
         return SAMPLE_MAX;
      end else if (quot < $signed(QUOT_W'(SAMPLE_MIN))) begin
         return SAMPLE_MIN;
      end
      return quot[SAMPLE_W-1:0];
   endfunction

   // tap distance limited to 1..DEPTH-1
   function automatic addr_type clamp_dist(dist_type d);
      if (d < DIST_MIN) begin
         return addr_type'(1);
      end else if (d > DIST_MAX) begin
         return ADDR_LAST;
      end
      return d[ADDR_W-1:0];
   endfunction

   // pointer minus distance on the ring
   function automatic addr_type ring_sub(addr_type ptr, addr_type span);
      logic [ADDR_W:0] diff;
      logic [ADDR_W:0] wrapped;
      diff    = {1'b0, ptr} - {1'b0, span};
      wrapped = diff + (ADDR_W+1)'(DEPTH);
      return diff[ADDR_W] ? wrapped[ADDR_W-1:0] : diff[ADDR_W-1:0];
   endfunction

   function automatic addr_type ring_next(addr_type ptr);
      return (ptr == ADDR_LAST) ? addr_type'(0) : ptr + addr_type'(1);
   endfunction

endpackage

// ----- rtl/sfdl_req_if.sv -----
// ----------------------------------------------------------------------------
// sfdl_req_if
// Input frame channel: one stereo frame per transfer.
// ----------------------------------------------------------------------------
interface sfdl_req_if;
   logic                 valid;
   logic                 ready;
   sfdl_pkg::sample_type left_in;
   sfdl_pkg::sample_type right_in;

   modport source (output valid, output left_in, output right_in, input ready);
   modport sink   (input valid, input left_in, input right_in, output ready);
endinterface

// ----- rtl/sfdl_rsp_if.sv -----
// ----------------------------------------------------------------------------
// sfdl_rsp_if
// Result frame channel: one stereo frame per transfer.
// ----------------------------------------------------------------------------
interface sfdl_rsp_if;
   logic                 valid;
   logic                 ready;
   sfdl_pkg::sample_type left_out;
   sfdl_pkg::sample_type right_out;

   modport source (output valid, output left_out, output right_out, input ready);
   modport sink   (input valid, input left_out, input right_out, output ready);
endinterface

// ----- rtl/sfdl_csr_if.sv -----
// ----------------------------------------------------------------------------
// sfdl_csr_if
// Register write channel: register index and write data per transfer.
// ----------------------------------------------------------------------------
interface sfdl_csr_if;
   logic                   valid;
   logic                   ready;
   sfdl_pkg::csr_idx_type  index;
   sfdl_pkg::csr_data_type data;

   modport source (output valid, output index, output data, input ready);
   modport sink   (input valid, input index, input data, output ready);
endinterface

// ----- rtl/sfdl_ram.sv -----
// ----------------------------------------------------------------------------
// sfdl_ram
// Generic simple dual-port RAM, one write and one registered read port.
// ----------------------------------------------------------------------------
module sfdl_ram #(
   parameter int WIDTH = 16,
   parameter int DEPTH = 1024
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // read returns the old word on a same-address write
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ----- rtl/sfdl_mix.sv -----
// ----------------------------------------------------------------------------
// sfdl_mix
// Per-channel mix: feedback product, write-back sum and output sum with
// rounding and saturation.
// ----------------------------------------------------------------------------
module sfdl_mix (
   input  sfdl_pkg::sample_type           tap,
   input  sfdl_pkg::prod_type             x_wet,
   input  sfdl_pkg::prod_type             x_dry,
   input  logic [sfdl_pkg::FB_W-1:0]      feedback_gain,
   output sfdl_pkg::sample_type           stored,
   output sfdl_pkg::sample_type           mix_out
);

   sfdl_pkg::prod_type tap_fb;
   sfdl_pkg::acc_type  wet_acc;
   sfdl_pkg::acc_type  out_acc;

   assign tap_fb  = tap * $signed({1'b0, feedback_gain});
   assign wet_acc = sfdl_pkg::acc_type'(x_wet) + sfdl_pkg::acc_type'(tap_fb);
   // tap at unity gain is a plain shift into the q15 accumulator
   assign out_acc = sfdl_pkg::acc_type'(x_dry)
                  + (sfdl_pkg::acc_type'(tap) <<< sfdl_pkg::FRAC_BITS);

   assign stored  = sfdl_pkg::round_sat(wet_acc);
   assign mix_out = sfdl_pkg::round_sat(out_acc);

endmodule

// ----- rtl/stereo_feedback_delay_line.sv -----
// ----------------------------------------------------------------------------
// stereo_feedback_delay_line
// Stereo feedback delay with spread between the left and right taps.
// ----------------------------------------------------------------------------
// Takes one stereo frame per clock and returns one per clock when the output
// side is not stalled; a frame passes stage s1, stage s2 and the output
// register in turn. Each channel has a 65536-entry sample memory with one
// write and one read port: the tap is read when the frame is taken, the mixed
// sample is written back as the frame leaves stage s2, and the two newest
// write-backs are forwarded to the tap so short delays see current data. The
// feedback multiply, sum and saturation of one frame are combinational within
// stage s2, which closes the loop from one frame to the next at one frame per
// clock. After reset a clearing pass zeroes both memories, one address per
// cycle; no frame is taken during it, while register writes are taken at any
// time. Tap distances are delay plus spread (left) and delay minus spread
// (right), limited to 1..65535 samples.
module stereo_feedback_delay_line (
   input  logic        clock,
   input  logic        reset,
   sfdl_csr_if.sink    csr_ch,
   sfdl_req_if.sink    req_ch,
   sfdl_rsp_if.source  rsp_ch
);

   // configuration
   logic [sfdl_pkg::DELAY_W-1:0]  delay_ff;
   logic [sfdl_pkg::SPREAD_W-1:0] spread_ff;
   logic [sfdl_pkg::FB_W-1:0]     feedback_ff;
   logic [sfdl_pkg::WET_W-1:0]    wet_ff;

   // clearing pass and write pointer
   logic               clear_busy_ff;
   sfdl_pkg::addr_type clear_addr_ff;
   sfdl_pkg::addr_type wp_ff;

   // pipeline
   logic                 s1_valid_ff;
   sfdl_pkg::sample_type s1_x_left_ff;
   sfdl_pkg::sample_type s1_x_right_ff;
   sfdl_pkg::addr_type   s1_wp_ff;
   sfdl_pkg::addr_type   s1_rd_left_ff;
   sfdl_pkg::addr_type   s1_rd_right_ff;

   logic                 s2_valid_ff;
   sfdl_pkg::prod_type   s2_xw_left_ff;
   sfdl_pkg::prod_type   s2_xd_left_ff;
   sfdl_pkg::prod_type   s2_xw_right_ff;
   sfdl_pkg::prod_type   s2_xd_right_ff;
   sfdl_pkg::sample_type s2_tap_left_ff;
   sfdl_pkg::sample_type s2_tap_right_ff;
   sfdl_pkg::addr_type   s2_wp_ff;
   sfdl_pkg::addr_type   s2_rd_left_ff;
   sfdl_pkg::addr_type   s2_rd_right_ff;

   // two newest write-backs
   logic                 h1_valid_ff;
   sfdl_pkg::addr_type   h1_addr_ff;
   sfdl_pkg::sample_type h1_left_ff;
   sfdl_pkg::sample_type h1_right_ff;
   logic                 h2_valid_ff;
   sfdl_pkg::addr_type   h2_addr_ff;
   sfdl_pkg::sample_type h2_left_ff;
   sfdl_pkg::sample_type h2_right_ff;

   logic                 out_valid_ff;
   sfdl_pkg::sample_type out_left_ff;
   sfdl_pkg::sample_type out_right_ff;

   // combinational
   logic                       accept;
   logic                       out_free;
   logic                       s2_move;
   logic                       s2_free;
   logic                       s1_move;
   logic                       s1_free;
   sfdl_pkg::dist_type         sum_left;
   sfdl_pkg::dist_type         sum_right;
   sfdl_pkg::addr_type         rd_left;
   sfdl_pkg::addr_type         rd_right;
   logic [sfdl_pkg::WET_W-1:0] wet_eff;
   logic [sfdl_pkg::WET_W-1:0] dry_eff;
   sfdl_pkg::prod_type         xw_left;
   sfdl_pkg::prod_type         xd_left;
   sfdl_pkg::prod_type         xw_right;
   sfdl_pkg::prod_type         xd_right;
   sfdl_pkg::sample_type       ram_left_q;
   sfdl_pkg::sample_type       ram_right_q;
   sfdl_pkg::sample_type       tap_left;
   sfdl_pkg::sample_type       tap_right;
   sfdl_pkg::sample_type       stored_left;
   sfdl_pkg::sample_type       stored_right;
   sfdl_pkg::sample_type       mix_left;
   sfdl_pkg::sample_type       mix_right;
   logic                       ram_we;
   sfdl_pkg::addr_type         ram_waddr;
   sfdl_pkg::sample_type       ram_wdata_left;
   sfdl_pkg::sample_type       ram_wdata_right;

   // ---------------------------------------------------------------- control
   assign out_free = !out_valid_ff || rsp_ch.ready;
   assign s2_move  = s2_valid_ff && out_free;
   assign s2_free  = !s2_valid_ff || s2_move;
   assign s1_move  = s1_valid_ff && s2_free;
   assign s1_free  = !s1_valid_ff || s1_move;

   assign req_ch.ready = !clear_busy_ff && s1_free;
   assign accept       = req_ch.valid && req_ch.ready;
   assign csr_ch.ready = 1'b1;

   // ------------------------------------------------------------ tap address
   assign sum_left  = sfdl_pkg::DIST_W'(delay_ff) + sfdl_pkg::DIST_W'(spread_ff);
   assign sum_right = sfdl_pkg::DIST_W'(delay_ff) - sfdl_pkg::DIST_W'(spread_ff);
   assign rd_left   = sfdl_pkg::ring_sub(wp_ff, sfdl_pkg::clamp_dist(sum_left));
   assign rd_right  = sfdl_pkg::ring_sub(wp_ff, sfdl_pkg::clamp_dist(sum_right));

   // ------------------------------------------------------------- dry / wet
   assign wet_eff  = (wet_ff > sfdl_pkg::WET_UNITY) ? sfdl_pkg::WET_UNITY : wet_ff;
   assign dry_eff  = sfdl_pkg::WET_UNITY - wet_eff;
   assign xw_left  = s1_x_left_ff  * $signed({1'b0, wet_eff});
   assign xd_left  = s1_x_left_ff  * $signed({1'b0, dry_eff});
   assign xw_right = s1_x_right_ff * $signed({1'b0, wet_eff});
   assign xd_right = s1_x_right_ff * $signed({1'b0, dry_eff});

   // newest write to the tap address wins over the memory word
   always_comb begin
      if (h1_valid_ff && h1_addr_ff == s2_rd_left_ff) begin
         tap_left = h1_left_ff;
      end else if (h2_valid_ff && h2_addr_ff == s2_rd_left_ff) begin
         tap_left = h2_left_ff;
      end else begin
         tap_left = s2_tap_left_ff;
      end
      if (h1_valid_ff && h1_addr_ff == s2_rd_right_ff) begin
         tap_right = h1_right_ff;
      end else if (h2_valid_ff && h2_addr_ff == s2_rd_right_ff) begin
         tap_right = h2_right_ff;
      end else begin
         tap_right = s2_tap_right_ff;
      end
   end

   sfdl_mix u_mix_left (
      .tap           (tap_left),
      .x_wet         (s2_xw_left_ff),
      .x_dry         (s2_xd_left_ff),
      .feedback_gain (feedback_ff),
      .stored        (stored_left),
      .mix_out       (mix_left)
   );

   sfdl_mix u_mix_right (
      .tap           (tap_right),
      .x_wet         (s2_xw_right_ff),
      .x_dry         (s2_xd_right_ff),
      .feedback_gain (feedback_ff),
      .stored        (stored_right),
      .mix_out       (mix_right)
   );

   // ---------------------------------------------------------------- memory
   assign ram_we          = clear_busy_ff || s2_move;
   assign ram_waddr       = clear_busy_ff ? clear_addr_ff : s2_wp_ff;
   assign ram_wdata_left  = clear_busy_ff ? sfdl_pkg::sample_type'(0) : stored_left;
   assign ram_wdata_right = clear_busy_ff ? sfdl_pkg::sample_type'(0) : stored_right;

   sfdl_ram #(
      .WIDTH (sfdl_pkg::SAMPLE_W),
      .DEPTH (sfdl_pkg::DEPTH)
   ) u_ram_left (
      .clock   (clock),
      .wr_en   (ram_we),
      .wr_addr (ram_waddr),
      .wr_data (ram_wdata_left),
      .rd_en   (accept),
      .rd_addr (rd_left),
      .rd_data (ram_left_q)
   );

   sfdl_ram #(
      .WIDTH (sfdl_pkg::SAMPLE_W),
      .DEPTH (sfdl_pkg::DEPTH)
   ) u_ram_right (
      .clock   (clock),
      .wr_en   (ram_we),
      .wr_addr (ram_waddr),
      .wr_data (ram_wdata_right),
      .rd_en   (accept),
      .rd_addr (rd_right),
      .rd_data (ram_right_q)
   );

   // ------------------------------------------------------- control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         delay_ff      <= sfdl_pkg::DELAY_RESET;
         spread_ff     <= sfdl_pkg::SPREAD_RESET;
         feedback_ff   <= sfdl_pkg::FEEDBACK_RESET;
         wet_ff        <= sfdl_pkg::WET_RESET;
         clear_busy_ff <= 1'b1;
         clear_addr_ff <= '0;
         wp_ff         <= '0;
         s1_valid_ff   <= 1'b0;
         s2_valid_ff   <= 1'b0;
         out_valid_ff  <= 1'b0;
         h1_valid_ff   <= 1'b0;
         h2_valid_ff   <= 1'b0;
      end else begin
         if (csr_ch.valid) begin
            case (csr_ch.index)
               sfdl_pkg::CSR_DELAY:    delay_ff    <= csr_ch.data[sfdl_pkg::DELAY_W-1:0];
               sfdl_pkg::CSR_SPREAD:   spread_ff   <= csr_ch.data[sfdl_pkg::SPREAD_W-1:0];
               sfdl_pkg::CSR_FEEDBACK: feedback_ff <= csr_ch.data[sfdl_pkg::FB_W-1:0];
               sfdl_pkg::CSR_WET:      wet_ff      <= csr_ch.data[sfdl_pkg::WET_W-1:0];
               default: ;
            endcase
         end
         if (clear_busy_ff) begin
            clear_addr_ff <= sfdl_pkg::ring_next(clear_addr_ff);
            if (clear_addr_ff == sfdl_pkg::ADDR_LAST) begin
               clear_busy_ff <= 1'b0;
            end
         end
         if (accept) begin
            wp_ff <= sfdl_pkg::ring_next(wp_ff);
         end
         if (s1_free) begin
            s1_valid_ff <= accept;
         end
         if (s2_free) begin
            s2_valid_ff <= s1_move;
         end
         if (s2_move) begin
            out_valid_ff <= 1'b1;
            h1_valid_ff  <= 1'b1;
            h2_valid_ff  <= h1_valid_ff;
         end else if (rsp_ch.ready) begin
            out_valid_ff <= 1'b0;
         end
      end
   end

   // ------------------------------------------------------- payload registers
   always_ff @(posedge clock) begin
      if (accept) begin
         s1_x_left_ff   <= req_ch.left_in;
         s1_x_right_ff  <= req_ch.right_in;
         s1_wp_ff       <= wp_ff;
         s1_rd_left_ff  <= rd_left;
         s1_rd_right_ff <= rd_right;
      end
      if (s1_move) begin
         s2_xw_left_ff   <= xw_left;
         s2_xd_left_ff   <= xd_left;
         s2_xw_right_ff  <= xw_right;
         s2_xd_right_ff  <= xd_right;
         s2_tap_left_ff  <= ram_left_q;
         s2_tap_right_ff <= ram_right_q;
         s2_wp_ff        <= s1_wp_ff;
         s2_rd_left_ff   <= s1_rd_left_ff;
         s2_rd_right_ff  <= s1_rd_right_ff;
      end
      if (s2_move) begin
         out_left_ff  <= mix_left;
         out_right_ff <= mix_right;
         h1_addr_ff   <= s2_wp_ff;
         h1_left_ff   <= stored_left;
         h1_right_ff  <= stored_right;
         h2_addr_ff   <= h1_addr_ff;
         h2_left_ff   <= h1_left_ff;
         h2_right_ff  <= h1_right_ff;
      end
   end

   assign rsp_ch.valid     = out_valid_ff;
   assign rsp_ch.left_out  = out_left_ff;
   assign rsp_ch.right_out = out_right_ff;

   // ------------------------------------------------------------ assertions
   a_no_frame_while_clearing: assert property (
      @(posedge clock) disable iff (reset)
      clear_busy_ff |-> !accept && !s2_move
   ) else $error("frame traffic during memory clearing pass");

   a_tap_not_write_slot: assert property (
      @(posedge clock) disable iff (reset)
      accept |-> (rd_left != wp_ff) && (rd_right != wp_ff)
   ) else $error("tap address equals the slot being written");

   a_history_is_previous_frame: assert property (
      @(posedge clock) disable iff (reset)
      (s2_valid_ff && h1_valid_ff) |-> sfdl_pkg::ring_next(h1_addr_ff) == s2_wp_ff
   ) else $error("newest write-back is not the preceding frame");

endmodule

// ----- verif/sfdl_check_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sfdl_check_pkg
// Scoreboard for the stereo feedback delay line: keeps its own copy of both
// sample memories, the write pointer and the registers, works out the echo
// frame for every frame taken in, and compares the frames that come out.
// ----------------------------------------------------------------------------
package sfdl_check_pkg;

   import sfdl_pkg::*;

   localparam int LEFT_CH   = 0;
   localparam int RIGHT_CH  = 1;
   localparam int MAX_SHOWN = 10;

   typedef struct {
      sample_type left;
      sample_type right;
   } stereo_frame_type;

   class delay_line_scoreboard;
      sample_type             history [2][DEPTH];
      int unsigned            write_ptr;
      logic [DELAY_W-1:0]     delay_reg;
      logic [SPREAD_W-1:0]    spread_reg;
      logic [FB_W-1:0]        fb_reg;
      logic [WET_W-1:0]       wet_reg;
      stereo_frame_type       expected_frames [$];
      int unsigned            mismatch_count;
      int unsigned            compared_count;

      function new();
         foreach (history[c, a]) history[c][a] = '0;
         write_ptr      = 0;
         delay_reg      = DELAY_RESET;
         spread_reg     = SPREAD_RESET;
         fb_reg         = FEEDBACK_RESET;
         wet_reg        = WET_RESET;
         mismatch_count = 0;
         compared_count = 0;
      endfunction

      function void write_register(csr_idx_type idx, csr_data_type data);
         case (idx)
            CSR_DELAY:    delay_reg  = data[DELAY_W-1:0];
            CSR_SPREAD:   spread_reg = data[SPREAD_W-1:0];
            CSR_FEEDBACK: fb_reg     = data[FB_W-1:0];
            CSR_WET:      wet_reg    = data[WET_W-1:0];
            default:      ;
         endcase
      endfunction

      // round half up, floor shift, clamp to 16 bits
      function sample_type q15_sat(longint acc);
         longint q;
         q = (acc + ROUND_HALF) >>> FRAC_BITS;
         if (q > 32767) begin
            return SAMPLE_MAX;
         end else if (q < -32768) begin
            return SAMPLE_MIN;
         end
         return sample_type'(q);
      endfunction

      // one channel: read tap, write back mix, return dry plus tap
      function sample_type echo_channel(int ch, sample_type x, int span);
         longint      wet;
         longint      dry;
         int unsigned rd;
         sample_type  tap;
         longint      store_acc;
         longint      out_acc;
         if (span < 1) begin
            span = 1;
         end else if (span > DEPTH - 1) begin
            span = DEPTH - 1;
         end
         wet       = (wet_reg > WET_UNITY) ? UNITY : longint'(wet_reg);
         dry       = UNITY - wet;
         rd        = (write_ptr + DEPTH - span) % DEPTH;
         tap       = history[ch][rd];
         store_acc = longint'(x) * wet + longint'(tap) * longint'(fb_reg);
         out_acc   = longint'(x) * dry + longint'(tap) * UNITY;
         history[ch][write_ptr] = q15_sat(store_acc);
         return q15_sat(out_acc);
      endfunction

      function void take_frame(sample_type l, sample_type r);
         stereo_frame_type e;
         int               base;
         base    = int'(delay_reg);
         e.left  = echo_channel(LEFT_CH, l, base + int'(spread_reg));
         e.right = echo_channel(RIGHT_CH, r, base - int'(spread_reg));
         expected_frames.push_back(e);
         write_ptr = (write_ptr + 1) % DEPTH;
      endfunction

      function void flag(string what, int want, int got);
         mismatch_count++;
         if (mismatch_count <= MAX_SHOWN) begin
            $display("mismatch on result %0d, %s: expected %0d, got %0d",
                     compared_count, what, want, got);
         end
      endfunction

      function void check_frame(sample_type l, sample_type r);
         stereo_frame_type e;
         compared_count++;
         if (expected_frames.size() == 0) begin
            flag("unexpected frame, left", 0, int'(l));
            return;
         end
         e = expected_frames.pop_front();
         if (l !== e.left) begin
            flag("left_out", int'(e.left), int'(l));
         end
         if (r !== e.right) begin
            flag("right_out", int'(e.right), int'(r));
         end
      endfunction
   endclass

endpackage

// ----- verif/stereo_feedback_delay_line_test.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// stereo_feedback_delay_line_test
// Drives stereo frames and register writes into the delay line with random
// gaps and output stalls, and checks every echo frame against the scoreboard.
// A short directed part hits clamped taps, saturation, rounding ties and wet
// mix above unity; random phases follow with mostly short delays so that the
// feedback loop recirculates.
// ----------------------------------------------------------------------------
module stereo_feedback_delay_line_test;

   import sfdl_pkg::*;
   import sfdl_check_pkg::*;

   localparam int CYCLE_LIMIT    = 600000;
   localparam int DIRECTED_COUNT = 25;
   localparam int RANDOM_COUNT   = 1850;
   localparam int MAX_IDLE       = 14;

   logic clock;
   logic reset;

   sfdl_csr_if csr_ch ();
   sfdl_req_if req_ch ();
   sfdl_rsp_if rsp_ch ();

   stereo_feedback_delay_line u_dut (
      .clock  (clock),
      .reset  (reset),
      .csr_ch (csr_ch),
      .req_ch (req_ch),
      .rsp_ch (rsp_ch)
   );

   delay_line_scoreboard board = new();

   int unsigned cycle_count    = 0;
   int unsigned frames_sent    = 0;
   int unsigned settings_count = 0;
   int unsigned reg_writes     = 0;
   bit          sender_idles   = 1'b1;
   bit          receiver_idles = 1'b1;

   initial begin
      clock = 1'b0;
      forever #2 clock = ~clock;
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("timeout after %0d cycles", cycle_count);
         $display("CHECK FAILED");
         $finish;
      end
   end

   // result side: random stall before each transfer
   initial begin
      int stall;
      rsp_ch.ready <= 1'b0;
      @(posedge clock);
      forever begin
         stall = receiver_idles ? $urandom_range(0, MAX_IDLE) : 0;
         if (stall != 0) begin
            rsp_ch.ready <= 1'b0;
            repeat (stall) @(posedge clock);
         end
         rsp_ch.ready <= 1'b1;
         @(posedge clock);
         while (!rsp_ch.valid) @(posedge clock);
         board.check_frame(rsp_ch.left_out, rsp_ch.right_out);
      end
   end

   task automatic send_frame(sample_type l, sample_type r);
      int gap;
      gap = sender_idles ? $urandom_range(0, MAX_IDLE) : 0;
      if (gap != 0) begin
         req_ch.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_ch.valid    <= 1'b1;
      req_ch.left_in  <= l;
      req_ch.right_in <= r;
      @(posedge clock);
      while (!req_ch.ready) @(posedge clock);
      board.take_frame(l, r);
      frames_sent++;
   endtask

   // stop sending and wait for every outstanding echo frame
   task automatic settle();
      req_ch.valid <= 1'b0;
      while (board.expected_frames.size() != 0) @(posedge clock);
   endtask

   task automatic write_reg(csr_idx_type idx, csr_data_type data);
      csr_ch.valid <= 1'b1;
      csr_ch.index <= idx;
      csr_ch.data  <= data;
      @(posedge clock);
      while (!csr_ch.ready) @(posedge clock);
      board.write_register(idx, data);
      reg_writes++;
   endtask

   task automatic apply_settings(csr_data_type delay_v, csr_data_type spread_v,
                                 csr_data_type fb_v, csr_data_type wet_v);
      settle();
      write_reg(CSR_DELAY, delay_v);
      write_reg(CSR_SPREAD, spread_v);
      write_reg(CSR_FEEDBACK, fb_v);
      write_reg(CSR_WET, wet_v);
      // index past the register list must be ignored
      write_reg(csr_idx_type'($urandom_range(int'(CSR_WET) + 1, 15)),
                csr_data_type'($urandom_range(0, 65535)));
      csr_ch.valid <= 1'b0;
      settings_count++;
   endtask

   function automatic sample_type pick_sample();
      case ($urandom_range(0, 11))
         0:       return SAMPLE_MAX;
         1:       return SAMPLE_MIN;
         2:       return sample_type'($urandom_range(0, 3) - 2);
         default: return sample_type'($urandom_range(0, 65535));
      endcase
   endfunction

   initial begin
      csr_data_type delay_v;
      csr_data_type spread_v;
      csr_data_type fb_v;
      csr_data_type wet_v;
      int           phase_len;

      reset           <= 1'b1;
      req_ch.valid    <= 1'b0;
      req_ch.left_in  <= '0;
      req_ch.right_in <= '0;
      csr_ch.valid    <= 1'b0;
      csr_ch.index    <= '0;
      csr_ch.data     <= '0;
      repeat (2) @(posedge clock);
      reset <= 1'b0;

      // reset settings: half gain, rounding ties at +1 and -1
      send_frame(SAMPLE_MAX, SAMPLE_MIN);
      send_frame(SAMPLE_MIN, SAMPLE_MAX);
      send_frame(sample_type'(1), sample_type'(-1));
      send_frame(sample_type'(0), sample_type'(0));

      // zero delay clamps to one, full feedback, all wet: saturation both ways
      apply_settings(16'd0, 16'd0, 16'd32767, 16'd32768);
      repeat (4) send_frame(SAMPLE_MAX, SAMPLE_MAX);
      repeat (4) send_frame(SAMPLE_MIN, SAMPLE_MIN);

      // spread past delay drives the right tap below one, wet above unity
      apply_settings(16'd3, 16'd4095, 16'd0, 16'hFFFF);
      send_frame(sample_type'(12345), sample_type'(-12345));
      send_frame(sample_type'(-1), sample_type'(1));
      send_frame(SAMPLE_MAX, SAMPLE_MIN);
      send_frame(sample_type'(100), sample_type'(-100));
      send_frame(SAMPLE_MIN, SAMPLE_MAX);

      // left tap beyond the memory end clamps to the top, dry only
      apply_settings(16'hFFFF, 16'd4095, 16'd1, 16'd0);
      send_frame(SAMPLE_MAX, SAMPLE_MAX);
      send_frame(SAMPLE_MIN, SAMPLE_MIN);
      send_frame(sample_type'(7), sample_type'(-7));
      send_frame(sample_type'(0), sample_type'(-1));

      // small distances, smallest wet
      sender_idles = 1'b0;
      apply_settings(16'd2, 16'd1, 16'd16384, 16'd1);
      send_frame(sample_type'(1), sample_type'(-1));
      send_frame(sample_type'(-1), sample_type'(1));
      send_frame(sample_type'(16383), sample_type'(-16384));
      send_frame(sample_type'(3), sample_type'(-3));

      while (frames_sent < DIRECTED_COUNT + RANDOM_COUNT) begin
         case ($urandom_range(0, 9))
            0, 1, 2, 3, 4, 5: delay_v = csr_data_type'($urandom_range(0, 40));
            6, 7:             delay_v = csr_data_type'($urandom_range(0, 400));
            8:                delay_v = csr_data_type'($urandom_range(0, 65535));
            default:          delay_v = csr_data_type'($urandom_range(65000, 65535));
         endcase
         case ($urandom_range(0, 9))
            0, 1, 2, 3, 4: spread_v = csr_data_type'($urandom_range(0, 16));
            5, 6:          spread_v = csr_data_type'($urandom_range(0, 4095));
            // bits above the register width are dropped
            7:             spread_v = csr_data_type'($urandom_range(0, 65535));
            default:       spread_v = '0;
         endcase
         case ($urandom_range(0, 9))
            7:       fb_v = 16'd32767;
            8:       fb_v = 16'd0;
            9:       fb_v = csr_data_type'($urandom_range(0, 65535));
            default: fb_v = csr_data_type'($urandom_range(0, 32767));
         endcase
         case ($urandom_range(0, 9))
            6:       wet_v = WET_UNITY;
            7:       wet_v = csr_data_type'($urandom_range(32769, 65535));
            8:       wet_v = 16'd0;
            9:       wet_v = csr_data_type'($urandom_range(0, 65535));
            default: wet_v = csr_data_type'($urandom_range(0, 32768));
         endcase
         apply_settings(delay_v, spread_v, fb_v, wet_v);
         sender_idles   = ($urandom_range(0, 3) != 0);
         receiver_idles = ($urandom_range(0, 3) != 0);
         phase_len      = $urandom_range(60, 200);
         repeat (phase_len) send_frame(pick_sample(), pick_sample());
      end

      settle();
      repeat (20) @(posedge clock);

      $display("%0d frames sent over %0d register settings (%0d register writes)",
               frames_sent, settings_count, reg_writes);
      $display("%0d echo frames compared, %0d mismatches",
               board.compared_count, board.mismatch_count);
      if (board.mismatch_count == 0 && board.expected_frames.size() == 0) begin
         $display("CHECK OK");
      end else begin
         $display("CHECK FAILED");
      end
      $finish;
   end

endmodule
